/* hdl/etu_pkg.sv */
// ----------------------------------------------------------------------------
// etu_pkg
// Shared sizes, action codes, item types and helpers of the embedding table
// engine.
// ----------------------------------------------------------------------------
package etu_pkg;

    localparam int VOCAB_DEPTH = 256;
    localparam int EMBED_DIM   = 16;
    localparam int WORDS       = VOCAB_DEPTH * EMBED_DIM;
    localparam int ADDR_W      = $clog2(WORDS);
    localparam int ROW_W       = $clog2(VOCAB_DEPTH);
    localparam int COL_W       = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;

    localparam int DATA_W      = 32;
    localparam int PROD_W      = 49;
    localparam int VOCAB_W     = 9;
    localparam int RATE_W      = 16;
    localparam int ACT_W       = 3;
    localparam int ELEM_W      = 4;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [VOCAB_W-1:0] VOCAB_RESET = 9'd256;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd655;

    localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACCUM  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd4;

    localparam logic REG_VOCAB = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    localparam logic [ELEM_W-1:0] LAST_COL = ELEM_W'(EMBED_DIM - 1);

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic [ELEM_W-1:0] column;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                  input int unsigned col);
        int unsigned a;
        a = int'(row) * EMBED_DIM + col;
        return ADDR_W'(a);
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
        logic [DATA_W-1:0] r;
        if (v > $signed({3'b000, {(DATA_W-1){1'b1}}})) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < $signed({3'b111, {(DATA_W-1){1'b0}}})) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/etu_ram.sv */
// ----------------------------------------------------------------------------
// etu_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module etu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/etu_upd_pipe.sv */
// ----------------------------------------------------------------------------
// etu_upd_pipe
// Update sweep datapath: scales each gradient word by the learning rate and
// subtracts it from the matching weight word with saturation.
// ----------------------------------------------------------------------------
module etu_upd_pipe
    import etu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              issue,
    input  logic [ADDR_W-1:0] issue_addr,
    input  logic [RATE_W-1:0] learn_rate,
    input  logic [DATA_W-1:0] grad_rdata,
    input  logic [DATA_W-1:0] wt_rdata,
    output wr_req_t           wr,
    output logic              busy
);

    logic                     v1_reg;
    logic                     v2_reg;
    logic [ADDR_W-1:0]        addr1_reg;
    logic [ADDR_W-1:0]        addr2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0]        wt2_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DATA_W:0]   delta;
    logic signed [DATA_W+1:0] diff;

    assign prod_next = $signed({1'b0, learn_rate}) * $signed(grad_rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        addr1_reg <= issue_addr;
        if (v1_reg) begin
            prod_reg  <= prod_next;
            wt2_reg   <= wt_rdata;
            addr2_reg <= addr1_reg;
        end
    end

    // arithmetic shift by 16 rounds toward minus infinity
    assign delta = prod_reg[PROD_W-1:16];
    assign diff  = $signed({{2{wt2_reg[DATA_W-1]}}, wt2_reg})
                 - $signed({delta[DATA_W], delta});

    always_comb begin
        wr.en   = v2_reg;
        wr.addr = addr2_reg;
        wr.data = sat32(diff);
    end

    assign busy = v1_reg | v2_reg;

endmodule

/* hdl/etu_out_buf.sv */
// ----------------------------------------------------------------------------
// etu_out_buf
// Two-entry result buffer between the weight RAM read port and the master
// stream side.
// ----------------------------------------------------------------------------
module etu_out_buf
    import etu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  out_item_t  push_item,
    input  logic       pop_ready,
    output logic       out_valid,
    output out_item_t  out_item,
    output logic [1:0] count
);

    out_item_t  ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && pop_ready;
    assign out_item  = ent_reg[rptr_reg];
    assign count     = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/embedding_table_engine_unit.sv */
// ----------------------------------------------------------------------------
// embedding_table_engine_unit
// Embedding table with weight and gradient RAMs, lookup, gradient
// accumulation, gradient clear and an SGD update sweep.
// ----------------------------------------------------------------------------
// Loads and gradient accumulations may follow one another in every cycle;
// an accumulation is a read-modify-write of the gradient RAM with a forward
// of the word just written. A lookup holds the input side while its row is
// read, one weight RAM read per word, and its words leave through a
// two-entry buffer at one per cycle whenever the result side is ready,
// while the next item is taken. A gradient clear writes all
// VOCAB_DEPTH*EMBED_DIM gradient words, one gradient RAM write per cycle;
// the same clearing pass runs after reset, during which no item is
// accepted. An update sweep passes one word per cycle through a
// three-stage read, multiply and write-back pipeline.
// ----------------------------------------------------------------------------
module embedding_table_engine_unit
    import etu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // token[31:0], element[35:32], value[67:36]
    input  logic [ACT_W-1:0]      s_tuser,  // action[2:0]
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // word[31:0], column[35:32]
    output logic                  m_tlast
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [VOCAB_W-1:0] vocab_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [ADDR_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic               upd_done_reg, upd_done_next;
    logic [ROW_W-1:0]   lk_row_reg, lk_row_next;
    logic [COL_W-1:0]   lk_col_reg, lk_col_next;
    logic               rd_pend_reg;
    logic [ELEM_W-1:0]  pend_col_reg;
    logic               pend_last_reg;
    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [DATA_W-1:0]  s1_value_reg;
    logic               lw_valid_reg;
    logic [ADDR_W-1:0]  lw_addr_reg;
    logic [DATA_W-1:0]  lw_data_reg;

    logic [DATA_W-1:0]  s_token;
    logic [ELEM_W-1:0]  s_element;
    logic [DATA_W-1:0]  s_value;
    logic               s_accept;
    logic [31:0]        limit;
    logic [ROW_W-1:0]   sel_row;
    logic [ADDR_W-1:0]  item_addr;
    logic               elem_ok;
    logic               sweep_last;
    logic               lk_issue;
    logic               upd_issue;
    logic               clr_we;
    logic               acc_issue;
    logic               load_we;
    logic               cfg_we;
    logic [2:0]         credit;
    logic               pop;
    logic [DATA_W-1:0]  acc_old;
    logic [DATA_W-1:0]  acc_sum;
    logic [DATA_W-1:0]  wt_rdata;
    logic [DATA_W-1:0]  grad_rdata;
    logic               grad_we;
    logic [ADDR_W-1:0]  grad_waddr;
    logic [DATA_W-1:0]  grad_wdata;
    logic [ADDR_W-1:0]  grad_raddr;
    logic               wt_we;
    logic [ADDR_W-1:0]  wt_waddr;
    logic [DATA_W-1:0]  wt_wdata;
    logic [ADDR_W-1:0]  wt_raddr;
    logic               upd_busy;
    wr_req_t            upd_wr;
    out_item_t          push_item;
    out_item_t          head_item;
    logic [1:0]         buf_count;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_reg <= VOCAB_RESET;
            rate_reg  <= RATE_RESET;
        end else if (cfg_we) begin
            case (paddr[2])
                REG_VOCAB: vocab_reg <= pwdata[VOCAB_W-1:0];
                REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VOCAB: prdata = {{(APB_DATA_W-VOCAB_W){1'b0}}, vocab_reg};
            REG_RATE:  prdata = {{(APB_DATA_W-RATE_W){1'b0}}, rate_reg};
            default:   prdata = '0;
        endcase
    end

    // input decode and token clamp
    assign s_token   = s_tdata[31:0];
    assign s_element = s_tdata[35:32];
    assign s_value   = s_tdata[67:36];

    assign limit   = (32'(vocab_reg) > 32'(VOCAB_DEPTH)) ? 32'(VOCAB_DEPTH) : 32'(vocab_reg);
    assign sel_row = (s_token[31] || ({1'b0, s_token[30:0]} >= limit))
                   ? '0 : ROW_W'(s_token);
    assign elem_ok   = (int'(s_element) < EMBED_DIM);
    assign item_addr = addr_of(sel_row, int'(s_element));

    // sweeps wait for a pending gradient write to land
    assign s_tready = (state_reg == ST_IDLE)
                   && !(s1_valid_reg && ((s_tuser == ACT_CLEAR) || (s_tuser == ACT_UPDATE)));
    assign s_accept = s_tvalid && s_tready;

    assign load_we   = s_accept && (s_tuser == ACT_LOAD) && elem_ok;
    assign acc_issue = s_accept && (s_tuser == ACT_ACCUM) && elem_ok;

    assign sweep_last = (sweep_cnt_reg == ADDR_W'(WORDS - 1));
    assign pop        = m_tvalid && m_tready;
    assign credit     = {1'b0, buf_count} + {2'b00, rd_pend_reg} - {2'b00, pop};

    // control sequencer
    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        upd_done_next  = upd_done_reg;
        lk_row_next    = lk_row_reg;
        lk_col_next    = lk_col_reg;
        lk_issue       = 1'b0;
        upd_issue      = 1'b0;
        clr_we         = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_we = 1'b1;
                if (sweep_last) begin
                    sweep_cnt_next = '0;
                    state_next     = ST_IDLE;
                end else begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        ACT_LOOKUP: begin
                            lk_row_next = sel_row;
                            lk_col_next = '0;
                            state_next  = ST_LOOKUP;
                        end
                        ACT_CLEAR: begin
                            sweep_cnt_next = '0;
                            state_next     = ST_CLEAR;
                        end
                        ACT_UPDATE: begin
                            sweep_cnt_next = '0;
                            upd_done_next  = 1'b0;
                            state_next     = ST_UPDATE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (credit < 3'd2) begin
                    lk_issue = 1'b1;
                    if (lk_col_reg == COL_W'(EMBED_DIM - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        lk_col_next = lk_col_reg + 1'b1;
                    end
                end
            end
            ST_UPDATE: begin
                if (!upd_done_reg) begin
                    upd_issue = 1'b1;
                    if (sweep_last) begin
                        upd_done_next = 1'b1;
                    end else begin
                        sweep_cnt_next = sweep_cnt_reg + 1'b1;
                    end
                end else if (!upd_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            sweep_cnt_reg <= '0;
            upd_done_reg  <= 1'b0;
            rd_pend_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            upd_done_reg  <= upd_done_next;
            rd_pend_reg   <= lk_issue;
            s1_valid_reg  <= acc_issue;
            lw_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        lk_row_reg <= lk_row_next;
        lk_col_reg <= lk_col_next;
        if (lk_issue) begin
            pend_col_reg  <= ELEM_W'(lk_col_reg);
            pend_last_reg <= (lk_col_reg == COL_W'(EMBED_DIM - 1));
        end
        if (acc_issue) begin
            s1_addr_reg  <= item_addr;
            s1_value_reg <= s_value;
        end
        if (s1_valid_reg) begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= acc_sum;
        end
    end

    // gradient accumulate with forward of the previous write
    assign acc_old = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : grad_rdata;
    assign acc_sum = sat32($signed({{2{acc_old[DATA_W-1]}}, acc_old})
                         + $signed({{2{s1_value_reg[DATA_W-1]}}, s1_value_reg}));

    // gradient ram ports
    assign grad_we    = clr_we || s1_valid_reg;
    assign grad_waddr = clr_we ? sweep_cnt_reg : s1_addr_reg;
    assign grad_wdata = clr_we ? '0 : acc_sum;
    assign grad_raddr = upd_issue ? sweep_cnt_reg : item_addr;

    etu_ram #(
        .WIDTH(DATA_W),
        .DEPTH(WORDS)
    ) u_grad_ram (
        .aclk  (aclk),
        .we    (grad_we),
        .waddr (grad_waddr),
        .wdata (grad_wdata),
        .re    (upd_issue || acc_issue),
        .raddr (grad_raddr),
        .rdata (grad_rdata)
    );

    // weight ram ports
    assign wt_we    = load_we || upd_wr.en;
    assign wt_waddr = upd_wr.en ? upd_wr.addr : item_addr;
    assign wt_wdata = upd_wr.en ? upd_wr.data : s_value;
    assign wt_raddr = lk_issue ? addr_of(lk_row_reg, int'(lk_col_reg)) : sweep_cnt_reg;

    etu_ram #(
        .WIDTH(DATA_W),
        .DEPTH(WORDS)
    ) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .re    (lk_issue || upd_issue),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    etu_upd_pipe u_upd_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (upd_issue),
        .issue_addr (sweep_cnt_reg),
        .learn_rate (rate_reg),
        .grad_rdata (grad_rdata),
        .wt_rdata   (wt_rdata),
        .wr         (upd_wr),
        .busy       (upd_busy)
    );

    // result buffer
    always_comb begin
        push_item.word   = wt_rdata;
        push_item.column = pend_col_reg;
        push_item.last   = pend_last_reg;
    end

    etu_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rd_pend_reg),
        .push_item (push_item),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_item  (head_item),
        .count     (buf_count)
    );

    assign m_tdata = {{(M_TDATA_W-DATA_W-ELEM_W){1'b0}}, head_item.column, head_item.word};
    assign m_tlast = head_item.last;

endmodule

/* hdl/etu_checker.sv */
// ----------------------------------------------------------------------------
// etu_checker
// Port-level checks of the embedding table engine, bound to the top level.
// ----------------------------------------------------------------------------
module etu_checker
    import etu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [ACT_W-1:0]     s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result item changed");

    // a lookup owns the input side while its row is read
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_LOOKUP) |=> !s_tready)
        else $error("item accepted during lookup");

    // sweeps block the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && ((s_tuser == ACT_CLEAR) || (s_tuser == ACT_UPDATE))
        |=> !s_tready ##1 !s_tready)
        else $error("item accepted during sweep");

    // last marks the final column of a row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[35:32] == LAST_COL))
        else $error("last on wrong column");

endmodule

bind embedding_table_engine_unit etu_checker u_etu_checker (.*);

/* tb/embedding_table_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// embedding_table_engine_unit_tb
// Self-checking bench for the embedding table engine. A shadow copy of the
// weight and gradient tables follows every accepted item on the input
// stream and queues the row words that each lookup must return. The words
// leaving the result stream are checked in order against that queue. The
// whole weight table is loaded first, so that no lookup or update ever
// reads an unwritten word. Directed items then cover the token clamp
// edges, accumulate and update saturation, clear and unknown actions.
// Random phases follow under several register settings. Both streams idle
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module embedding_table_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import etu_pkg::*;

    localparam int GAP_MAX      = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_CYCLES = WORDS + 104;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 20;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [ACT_W-1:0]         ACT_TOP = '1;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // token[31:0], element[35:32], value[67:36]
    logic [ACT_W-1:0]      s_tuser  = '0;  // action[2:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // word[31:0], column[35:32]
    logic                  m_tlast;

    bit calm        = 1'b0;
    bit hold_rx_req = 1'b0;

    embedding_table_engine_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    class table_shadow;
        logic signed [DATA_W-1:0] weights [WORDS];
        logic signed [DATA_W-1:0] grads   [WORDS];
        logic [VOCAB_W-1:0]       vocab;
        logic [RATE_W-1:0]        rate;
        out_item_t                pending_words [$];
        int                       mismatches;

        function new();
            vocab = VOCAB_RESET;
            rate = RATE_RESET;
            mismatches = 0;
            foreach (weights[i]) begin
                weights[i] = '0;
                grads[i] = '0;
            end
        endfunction

        function void set_reg(logic idx, logic [APB_DATA_W-1:0] data);
            if (idx == REG_VOCAB) begin
                vocab = data[VOCAB_W-1:0];
            end else begin
                rate = data[RATE_W-1:0];
            end
        endfunction

        function int unsigned row_of(logic signed [DATA_W-1:0] token);
            longint limit;
            limit = (vocab > VOCAB_DEPTH) ? VOCAB_DEPTH : vocab;
            if (token < 0 || longint'(token) >= limit) begin
                return 0;
            end
            return int'(token);
        endfunction

        function logic signed [DATA_W-1:0] clip(longint v);
            if (v > longint'(S32_MAX)) begin
                return S32_MAX;
            end
            if (v < longint'(S32_MIN)) begin
                return S32_MIN;
            end
            return DATA_W'(v);
        endfunction

        function void take_item(logic [ACT_W-1:0] action, logic signed [DATA_W-1:0] token,
                                logic [ELEM_W-1:0] element,
                                logic signed [DATA_W-1:0] value);
            int unsigned base;
            int unsigned k;
            longint      prod;
            out_item_t   w;
            base = row_of(token) * EMBED_DIM;
            k = base + element;
            case (action)
                ACT_LOAD: begin
                    if (element < EMBED_DIM) begin
                        weights[k] = value;
                    end
                end
                ACT_LOOKUP: begin
                    for (int i = 0; i < EMBED_DIM; i++) begin
                        w.word = weights[base + i];
                        w.column = ELEM_W'(i);
                        w.last = (i == EMBED_DIM - 1);
                        pending_words.push_back(w);
                    end
                end
                ACT_ACCUM: begin
                    if (element < EMBED_DIM) begin
                        grads[k] = clip(longint'(grads[k]) + longint'(value));
                    end
                end
                ACT_CLEAR: begin
                    foreach (grads[i]) begin
                        grads[i] = '0;
                    end
                end
                ACT_UPDATE: begin
                    foreach (weights[i]) begin
                        prod = longint'(rate) * longint'(grads[i]);
                        weights[i] = clip(longint'(weights[i]) - (prod >>> 16));
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void match_word(logic [DATA_W-1:0] word, logic [ELEM_W-1:0] column,
                                 logic last);
            out_item_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result item: word %h column %0d last %b",
                             word, column, last);
                end
                return;
            end
            want = pending_words.pop_front();
            if (want.word !== word || want.column !== column || want.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result mismatch: expected word %h column %0d last %b",
                             want.word, want.column, want.last);
                    $display("                 actual   word %h column %0d last %b",
                             word, column, last);
                end
            end
        endfunction
    endclass

    table_shadow shadow = new();

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #6ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return S32_MAX;
        end
        if (sel == 1) begin
            return S32_MIN;
        end
        if (sel < 5) begin
            return $urandom;
        end
        return DATA_W'($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_token();
        int unsigned limit;
        int unsigned sel;
        limit = (shadow.vocab > VOCAB_DEPTH) ? VOCAB_DEPTH : shadow.vocab;
        sel = $urandom_range(0, 9);
        if (sel < 6 && limit > 0) begin
            return DATA_W'($urandom_range(0, limit - 1));
        end
        if (sel < 8) begin
            return DATA_W'($urandom_range(limit, VOCAB_DEPTH + 8));
        end
        if (sel == 8) begin
            return DATA_W'(0) - DATA_W'($urandom_range(1, 1000));
        end
        return $urandom;
    endfunction

    task automatic offer_item(logic [ACT_W-1:0] action, logic signed [DATA_W-1:0] token,
                              logic [ELEM_W-1:0] element, logic signed [DATA_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= S_TDATA_W'({value, element, token});
        do @(posedge aclk); while (s_tready !== 1'b1);
        shadow.take_item(action, token, element, value);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (shadow.pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow.set_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic configure(logic [VOCAB_W-1:0] vocab, logic [RATE_W-1:0] rate);
        wait_drained();
        // a sweep or clear may still be running with no result to show for it
        repeat (QUIET_CYCLES) @(posedge aclk);
        write_reg(REG_VOCAB, APB_DATA_W'(vocab));
        write_reg(REG_RATE, APB_DATA_W'(rate));
    endtask

    task automatic run_mix(int count);
        int          done;
        int unsigned sel;
        done = 0;
        while (done < count) begin
            sel = $urandom_range(0, 99);
            done++;
            if (sel < 25) begin
                offer_item(ACT_LOAD, pick_token(), ELEM_W'($urandom), pick_value());
            end else if (sel < 60) begin
                offer_item(ACT_LOOKUP, pick_token(), ELEM_W'($urandom), $urandom);
            end else if (sel < 88) begin
                offer_item(ACT_ACCUM, pick_token(), ELEM_W'($urandom), pick_value());
            end else if (sel < 91) begin
                offer_item(ACT_CLEAR, $urandom, ELEM_W'($urandom), $urandom);
            end else if (sel < 95) begin
                offer_item(ACT_UPDATE, $urandom, ELEM_W'($urandom), $urandom);
            end else begin
                offer_item(ACT_W'($urandom_range(ACT_UPDATE + 1, ACT_TOP)), $urandom,
                           ELEM_W'($urandom), $urandom);
                done--;
            end
        end
    endtask

    initial begin : result_sink
        int gap;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_rx_req) begin
                gap = HOLD_CYCLES;
                hold_rx_req = 1'b0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            shadow.match_word(m_tdata[DATA_W-1:0], m_tdata[DATA_W +: ELEM_W], m_tlast);
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // every weight word gets a value before any lookup or update
        for (int r = 0; r < VOCAB_DEPTH; r++) begin
            for (int c = 0; c < EMBED_DIM; c++) begin
                offer_item(ACT_LOAD, DATA_W'(r), ELEM_W'(c), pick_value());
            end
        end

        offer_item(ACT_LOOKUP, 32'sd0, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd255, 4'd15, 32'sd0);
        offer_item(ACT_LOOKUP, -32'sd1, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, S32_MIN, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, S32_MAX, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd256, 4'd0, 32'sd0);
        offer_item(ACT_LOAD, 32'sd5, LAST_COL, S32_MIN);
        offer_item(ACT_LOAD, 32'sd5, 4'd0, S32_MAX);
        offer_item(ACT_ACCUM, 32'sd5, LAST_COL, S32_MAX);
        offer_item(ACT_ACCUM, 32'sd5, LAST_COL, S32_MAX);
        offer_item(ACT_ACCUM, 32'sd5, 4'd0, S32_MIN);
        offer_item(ACT_ACCUM, 32'sd5, 4'd0, S32_MIN);
        offer_item(ACT_ACCUM, -32'sd7, 4'd3, 32'sh0001_8000);
        offer_item(ACT_ACCUM, 32'sd1000, 4'd9, -32'sh0000_4321);
        offer_item(ACT_TOP, S32_MAX, 4'd15, S32_MAX);
        offer_item(ACT_W'(ACT_UPDATE + 1), 32'sd5, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd5, 4'd0, 32'sd0);
        offer_item(ACT_UPDATE, 32'sd0, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd5, 4'd0, 32'sd0);
        configure(VOCAB_RESET, 16'hffff);
        offer_item(ACT_UPDATE, 32'sd0, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd5, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd0, 4'd0, 32'sd0);
        offer_item(ACT_CLEAR, 32'sd0, 4'd0, 32'sd0);
        offer_item(ACT_UPDATE, 32'sd0, 4'd0, 32'sd0);
        offer_item(ACT_LOOKUP, 32'sd5, 4'd0, 32'sd0);

        configure(9'd1, 16'd0);
        run_mix(PHASE_ITEMS);

        configure(VOCAB_RESET, 16'hffff);
        calm = 1'b1;
        run_mix(PHASE_ITEMS / 2);
        calm = 1'b0;
        // the result side stalls while lookups keep coming
        hold_rx_req = 1'b1;
        repeat (8) offer_item(ACT_LOOKUP, pick_token(), ELEM_W'($urandom), $urandom);
        run_mix(PHASE_ITEMS / 2);

        configure(9'd0, RATE_W'($urandom));
        run_mix(PHASE_ITEMS / 2);
        wait_drained();
        run_mix(PHASE_ITEMS / 2);

        configure(9'h1ff, RATE_RESET);
        run_mix(PHASE_ITEMS);

        configure(VOCAB_W'($urandom_range(1, VOCAB_DEPTH)), RATE_W'($urandom));
        run_mix(PHASE_ITEMS);

        wait_drained();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.pending_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/etu_pkg.sv
hdl/etu_ram.sv
hdl/etu_upd_pipe.sv
hdl/etu_out_buf.sv
hdl/embedding_table_engine_unit.sv
hdl/etu_checker.sv
tb/embedding_table_engine_unit_tb.sv
